### src/tzkm_pkg.sv
`default_nettype none

package tzkm_pkg;

  localparam int TYPE_W    = 5;
  localparam int CODE_W    = 10;
  localparam int VALUE_W   = 32;
  localparam int KEY_W     = 10;
  localparam int BTN_REG_W = 58;
  localparam int BTN_CNT_W = 3;
  localparam int REG_IDX_W = 3;

  localparam logic [TYPE_W-1:0] TYPE_SYNC = 5'd0;
  localparam logic [TYPE_W-1:0] TYPE_KEY  = 5'd1;
  localparam logic [TYPE_W-1:0] TYPE_ABS  = 5'd3;

  localparam logic [CODE_W-1:0] CODE_REPORT = 10'd0;
  localparam logic [CODE_W-1:0] CODE_X      = 10'd0;
  localparam logic [CODE_W-1:0] CODE_Y      = 10'd1;
  localparam logic [CODE_W-1:0] CODE_TOUCH  = 10'd330;

  localparam logic [REG_IDX_W-1:0] REG_BUTTON_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BUTTON_ZERO  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BUTTON_THREE = 3'd4;

  typedef enum logic [1:0] {
    TS_NONE     = 2'd0,
    TS_RELEASED = 2'd1,
    TS_TOUCHED  = 2'd2
  } touch_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  ev_type;
    logic [CODE_W-1:0]  ev_code;
    logic [VALUE_W-1:0] ev_value;
  } event_t;

  typedef struct packed {
    logic               x_seen;
    logic               y_seen;
    logic [VALUE_W-1:0] x;
    logic [VALUE_W-1:0] y;
  } frame_t;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] key;
  } zone_t;

endpackage

`default_nettype wire

### src/touch_zone_key_mapper_top.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    event_type, event_code, event_value
// output    out        out_valid / out_stall  out_type, out_code, out_value, out_last
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A buffered event is taken in the idle state and the next item can follow at once.
// A frame-end report starts the button scan, which visits each button and then
// chooses replay or report; a replay reads each stored event from memory and then
// loads it into the output register, and the closing report ends the frame.
// A new result waits while the output register is stalled.
// Synchronous reset clears the frame state, the latches, the button count and the button registers.
// The event store needs no clearing pass; only entries below the count are read.
`default_nettype none

module touch_zone_key_mapper_top import tzkm_pkg::*; #(
  parameter int QUEUE_DEPTH = 32,
  parameter int MAX_BUTTONS = 4,
  parameter int COORD_BITS  = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [TYPE_W-1:0]    event_type,
  input  wire logic [CODE_W-1:0]    event_code,
  input  wire logic signed [VALUE_W-1:0] event_value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [TYPE_W-1:0]         out_type,
  output logic [CODE_W-1:0]         out_code,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [BTN_REG_W-1:0] cfg_data
);

  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int BIW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_RD   = 5'b00100,
    S_OUT  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t                 state;
  logic [CW-1:0]          event_count;
  logic [CW-1:0]          rd_ptr;
  logic [VALUE_W-1:0]     frame_x;
  logic [VALUE_W-1:0]     frame_y;
  logic                   x_seen;
  logic                   y_seen;
  touch_t                 touch_state;
  logic [MAX_BUTTONS-1:0] latched;
  logic [BTN_CNT_W-1:0]   button_count;
  logic [BTN_REG_W-1:0]   btn_reg [MAX_BUTTONS];
  logic [BTN_CNT_W-1:0]   btn_idx;
  logic                   acted;

  logic                   is_report;
  logic                   store_wr;
  event_t                 store_in;
  event_t                 store_out;
  logic                   out_free;
  logic                   out_load;
  logic [BTN_CNT_W-1:0]   cnt_sat;
  logic                   idx_ok;
  logic                   scan_live;
  logic [BTN_REG_W-1:0]   btn_sel;
  logic                   lat_sel;
  frame_t                 frame;
  zone_t                  zone;
  logic                   do_press;
  logic                   do_release;
  logic                   need_emit;
  logic [BTN_CNT_W-1:0]   wr_btn;
  logic                   cfg_btn_ok;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign is_report = (event_type == TYPE_SYNC) && (event_code == CODE_REPORT);
  assign store_wr  = (state == S_IDLE) && in_valid && !is_report &&
                     (event_count < CW'(QUEUE_DEPTH));
  assign store_in  = '{ev_type: event_type, ev_code: event_code, ev_value: event_value};

  tzkm_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (event_count[AW-1:0]),
    .wr_data (store_in),
    .rd_en   (state == S_RD),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (store_out)
  );

  assign cnt_sat   = (button_count > BTN_CNT_W'(MAX_BUTTONS)) ?
                     BTN_CNT_W'(MAX_BUTTONS) : button_count;
  assign idx_ok    = (btn_idx < BTN_CNT_W'(MAX_BUTTONS));
  assign scan_live = (btn_idx < cnt_sat);
  assign btn_sel   = idx_ok ? btn_reg[btn_idx[BIW-1:0]] : '0;
  assign lat_sel   = idx_ok ? latched[btn_idx[BIW-1:0]] : 1'b0;
  assign frame     = '{x_seen: x_seen, y_seen: y_seen, x: frame_x, y: frame_y};

  tzkm_zone #(
    .COORD_BITS (COORD_BITS)
  ) u_zone (
    .button (btn_sel),
    .frame  (frame),
    .zone   (zone)
  );

  assign do_press   = (touch_state == TS_TOUCHED) && !lat_sel && zone.hit;
  assign do_release = !do_press && lat_sel && (touch_state == TS_RELEASED);
  assign need_emit  = scan_live && (do_press || do_release);

  // The sequencer loads a new item into the output register this cycle.
  assign out_load   = out_free && ((state == S_SCAN && need_emit) ||
                                   state == S_OUT || state == S_FIN);

  assign wr_btn     = cfg_index - REG_BUTTON_ZERO;
  assign cfg_btn_ok = (cfg_index >= REG_BUTTON_ZERO) && (cfg_index <= REG_BUTTON_THREE) &&
                      (wr_btn < BTN_CNT_W'(MAX_BUTTONS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      event_count  <= '0;
      rd_ptr       <= '0;
      frame_x      <= '0;
      frame_y      <= '0;
      x_seen       <= 1'b0;
      y_seen       <= 1'b0;
      touch_state  <= TS_NONE;
      latched      <= '0;
      button_count <= '0;
      btn_idx      <= '0;
      acted        <= 1'b0;
      out_valid    <= 1'b0;
      for (int i = 0; i < MAX_BUTTONS; i++) begin
        btn_reg[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BUTTON_COUNT) begin
          button_count <= cfg_data[BTN_CNT_W-1:0];
        end else if (cfg_btn_ok) begin
          btn_reg[wr_btn[BIW-1:0]] <= cfg_data;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (is_report) begin
              state   <= S_SCAN;
              btn_idx <= '0;
              acted   <= 1'b0;
            end else if (store_wr) begin
              event_count <= event_count + 1'b1;
              if (event_type == TYPE_ABS && event_code == CODE_X) begin
                frame_x <= event_value;
                x_seen  <= 1'b1;
              end else if (event_type == TYPE_ABS && event_code == CODE_Y) begin
                frame_y <= event_value;
                y_seen  <= 1'b1;
              end else if (event_type == TYPE_KEY && event_code == CODE_TOUCH) begin
                if (event_value == 32'sd1) begin
                  touch_state <= TS_TOUCHED;
                end else if (event_value == 32'sd0) begin
                  touch_state <= TS_RELEASED;
                end else begin
                  touch_state <= TS_NONE;
                end
              end
            end
          end
        end
        S_SCAN: begin
          if (!scan_live) begin
            rd_ptr <= '0;
            if (acted || event_count == '0) begin
              state <= S_FIN;
            end else begin
              state <= S_RD;
            end
          end else if (!need_emit || out_free) begin
            btn_idx <= btn_idx + 1'b1;
            if (do_press || lat_sel) begin
              acted <= 1'b1;
            end
            if (need_emit) begin
              out_type  <= TYPE_KEY;
              out_code  <= zone.key;
              out_value <= do_press ? 32'sd1 : 32'sd0;
              out_last  <= 1'b0;
              latched[btn_idx[BIW-1:0]] <= do_press;
            end
          end
        end
        S_RD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_type  <= store_out.ev_type;
            out_code  <= store_out.ev_code;
            out_value <= store_out.ev_value;
            out_last  <= 1'b0;
            rd_ptr    <= rd_ptr + 1'b1;
            if (rd_ptr + 1'b1 == event_count) begin
              state <= S_FIN;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_type    <= TYPE_SYNC;
            out_code    <= CODE_REPORT;
            out_value   <= 32'sd0;
            out_last    <= 1'b1;
            event_count <= '0;
            frame_x     <= '0;
            frame_y     <= '0;
            x_seen      <= 1'b0;
            y_seen      <= 1'b0;
            touch_state <= TS_NONE;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    event_count <= CW'(QUEUE_DEPTH))
    else $error("event count above store depth");

  a_replay_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_OUT) |-> (rd_ptr < event_count))
    else $error("replay pointer past stored events");

  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (btn_idx <= cnt_sat))
    else $error("button scan index past button count");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_free) |=> (event_count == '0 && !x_seen && !y_seen && out_last))
    else $error("frame state not cleared after closing report");
`endif

endmodule

`default_nettype wire

### src/tzkm_store.sv
`default_nettype none

module tzkm_store import tzkm_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire event_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output event_t             rd_data
);

  event_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### src/tzkm_zone.sv
`default_nettype none

module tzkm_zone import tzkm_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  wire logic [BTN_REG_W-1:0] button,
  input  wire frame_t               frame,
  output zone_t                     zone
);

  localparam int KEY_POS = 4 * COORD_BITS;
  localparam int EXT_W   = BTN_REG_W + KEY_POS + KEY_W;

  // Fields that reach past the register width read as zero.
  logic [EXT_W-1:0]      ext;
  logic [COORD_BITS-1:0] bx;
  logic [COORD_BITS-1:0] by;
  logic [COORD_BITS-1:0] bw;
  logic [COORD_BITS-1:0] bh;
  logic [VALUE_W-1:0]    x_lo;
  logic [VALUE_W-1:0]    x_hi;
  logic [VALUE_W-1:0]    y_lo;
  logic [VALUE_W-1:0]    y_hi;
  logic [VALUE_W-1:0]    xu;
  logic [VALUE_W-1:0]    yu;

  assign ext  = EXT_W'(button);
  assign bx   = ext[0 +: COORD_BITS];
  assign by   = ext[COORD_BITS +: COORD_BITS];
  assign bw   = ext[2 * COORD_BITS +: COORD_BITS];
  assign bh   = ext[3 * COORD_BITS +: COORD_BITS];
  assign x_lo = VALUE_W'(bx);
  assign y_lo = VALUE_W'(by);
  assign x_hi = VALUE_W'(bx) + VALUE_W'(bw);
  assign y_hi = VALUE_W'(by) + VALUE_W'(bh);
  assign xu   = {1'b0, frame.x[VALUE_W-2:0]};
  assign yu   = {1'b0, frame.y[VALUE_W-2:0]};

  // Negative coordinates never hit; the sign bit is checked apart.
  assign zone.hit = frame.x_seen && frame.y_seen &&
                    !frame.x[VALUE_W-1] && !frame.y[VALUE_W-1] &&
                    (x_lo <= xu) && (xu <= x_hi) &&
                    (y_lo <= yu) && (yu <= y_hi);
  assign zone.key = ext[KEY_POS +: KEY_W];

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tzkm_pkg::*;

  localparam int QUEUE_DEPTH   = 32;
  localparam int MAX_BUTTONS   = 4;
  localparam int COORD_BITS    = 12;
  localparam int DIRECTED_ROWS = 25;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 85;
  localparam int IDLE_PERCENT  = 26;
  localparam int HOLD_AT_ITEMS = 160;
  localparam int HOLD_CYCLES   = 400;
  // Covers the longest burst: a full replay, the scan and the closing report.
  localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + MAX_BUTTONS + 12;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 40;

  localparam logic [VALUE_W-1:0]   TOUCH_UP         = 32'd0;
  localparam logic [VALUE_W-1:0]   TOUCH_DOWN       = 32'd1;
  localparam logic [KEY_W-1:0]     KEY_ZONE0        = 10'd30;
  localparam logic [KEY_W-1:0]     KEY_ZONE3        = 10'd500;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_UNUSED = REG_BUTTON_THREE + 3'd1;

  typedef struct packed {
    logic [TYPE_W-1:0]  ev_type;
    logic [CODE_W-1:0]  ev_code;
    logic [VALUE_W-1:0] ev_value;
    logic               last;
  } out_event_t;

  // A directed row: the item, and up to two results typed in by hand.
  typedef struct packed {
    event_t     ev;
    logic [1:0] n_typed;
    out_event_t typed_a;
    out_event_t typed_b;
  } dir_row_t;

  localparam out_event_t REPORT_LAST = {TYPE_SYNC, CODE_REPORT, 32'd0, 1'b1};
  localparam out_event_t NO_RESULT   = '0;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [TYPE_W-1:0]         event_type;
  logic [CODE_W-1:0]         event_code;
  logic signed [VALUE_W-1:0] event_value;
  logic                      out_valid;
  logic                      out_stall;
  logic [TYPE_W-1:0]         out_type;
  logic [CODE_W-1:0]         out_code;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_last;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [REG_IDX_W-1:0]      cfg_index;
  logic [BTN_REG_W-1:0]      cfg_data;

  // Mirror of the mapper: frame tracking, latches and button registers.
  event_t                    stored_events [QUEUE_DEPTH];
  int unsigned               stored_count;
  logic signed [VALUE_W-1:0] last_x;
  logic signed [VALUE_W-1:0] last_y;
  bit                        x_valid;
  bit                        y_valid;
  touch_t                    touch;
  bit [MAX_BUTTONS-1:0]      latched;
  logic [BTN_CNT_W-1:0]      zone_count;
  logic [BTN_REG_W-1:0]      zone_reg [MAX_BUTTONS];

  out_event_t burst[$];
  out_event_t awaited_events[$];
  dir_row_t   directed [DIRECTED_ROWS];

  bit idle_enabled;
  int unsigned items_sent;
  int unsigned frames_closed;
  int unsigned key_presses;
  int unsigned key_releases;
  int unsigned results_checked;
  int unsigned input_stall_cycles;
  int unsigned mismatches;
  int unsigned cycle_count;

  touch_zone_key_mapper_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .event_type(event_type),
    .event_code(event_code),
    .event_value(event_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_type(out_type),
    .out_code(out_code),
    .out_value(out_value),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [BTN_REG_W-1:0] pack_button(input int unsigned x, input int unsigned y,
                                                       input int unsigned w, input int unsigned h,
                                                       input int unsigned key);
    return {key[KEY_W-1:0], h[COORD_BITS-1:0], w[COORD_BITS-1:0], y[COORD_BITS-1:0],
            x[COORD_BITS-1:0]};
  endfunction

  function automatic bit zone_hit(input logic [BTN_REG_W-1:0] zone);
    longint bx, by, bw, bh, x, y;
    bx = zone[0 +: COORD_BITS];
    by = zone[COORD_BITS +: COORD_BITS];
    bw = zone[2*COORD_BITS +: COORD_BITS];
    bh = zone[3*COORD_BITS +: COORD_BITS];
    x = last_x;
    y = last_y;
    if (!x_valid || !y_valid || x < 0 || y < 0) return 1'b0;
    return bx <= x && x <= bx + bw && by <= y && y <= by + bh;
  endfunction

  task automatic clear_frame();
    stored_count = 0;
    last_x = '0;
    last_y = '0;
    x_valid = 1'b0;
    y_valid = 1'b0;
    touch = TS_NONE;
  endtask

  // Works out the burst that one accepted item causes and advances the mirror.
  task automatic map_touch_event(input event_t ev);
    int unsigned scan;
    bit acted;
    logic [KEY_W-1:0] key;
    burst.delete();
    if (ev.ev_type != TYPE_SYNC || ev.ev_code != CODE_REPORT) begin
      if (stored_count < QUEUE_DEPTH) begin
        stored_events[stored_count] = ev;
        stored_count++;
        if (ev.ev_type == TYPE_ABS && ev.ev_code == CODE_X) begin
          last_x = ev.ev_value;
          x_valid = 1'b1;
        end else if (ev.ev_type == TYPE_ABS && ev.ev_code == CODE_Y) begin
          last_y = ev.ev_value;
          y_valid = 1'b1;
        end else if (ev.ev_type == TYPE_KEY && ev.ev_code == CODE_TOUCH) begin
          if (ev.ev_value == TOUCH_DOWN) touch = TS_TOUCHED;
          else if (ev.ev_value == TOUCH_UP) touch = TS_RELEASED;
          else touch = TS_NONE;
        end
      end
    end else begin
      frames_closed++;
      scan = zone_count > MAX_BUTTONS ? MAX_BUTTONS : zone_count;
      acted = 1'b0;
      for (int i = 0; i < scan; i++) begin
        key = zone_reg[i][4*COORD_BITS +: KEY_W];
        if (touch == TS_TOUCHED && !latched[i] && zone_hit(zone_reg[i])) begin
          burst.push_back({TYPE_KEY, key, TOUCH_DOWN, 1'b0});
          latched[i] = 1'b1;
          acted = 1'b1;
          key_presses++;
        end else if (latched[i]) begin
          if (touch == TS_RELEASED) begin
            burst.push_back({TYPE_KEY, key, TOUCH_UP, 1'b0});
            latched[i] = 1'b0;
            key_releases++;
          end
          acted = 1'b1;
        end
      end
      if (!acted) begin
        for (int i = 0; i < stored_count; i++) burst.push_back({stored_events[i], 1'b0});
      end
      burst.push_back(REPORT_LAST);
      clear_frame();
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [BTN_REG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_BUTTON_COUNT) zone_count = data[BTN_CNT_W-1:0];
    else if (idx >= REG_BUTTON_ZERO && idx <= REG_BUTTON_THREE) zone_reg[idx - REG_BUTTON_ZERO] = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offers one item, waits for it to be taken and, unless its results are typed, queues what it should cause.
  task automatic send_event(input event_t ev, input bit typed);
    @(negedge clk);
    while (idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    event_type <= ev.ev_type;
    event_code <= ev.ev_code;
    event_value <= ev.ev_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    map_touch_event(ev);
    if (!typed) begin
      foreach (burst[k]) awaited_events.push_back(burst[k]);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [BTN_REG_W-1:0] random_button();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return wide[BTN_REG_W-1:0];
    return pack_button($urandom_range(0, 3000), $urandom_range(0, 3000), $urandom_range(0, 600),
                       $urandom_range(0, 600), $urandom_range(0, 1023));
  endfunction

  // Edges, just outside on either side, anywhere, or inside the span.
  function automatic logic [VALUE_W-1:0] pick_coord(input int unsigned base, input int unsigned span);
    case ($urandom_range(0, 7))
      0: return base;
      1: return base + span;
      2: return base + span + 1;
      3: return base - 1;
      4: return $urandom;
      default: return base + $urandom_range(0, span);
    endcase
  endfunction

  function automatic event_t random_noise();
    event_t e;
    e = {5'($urandom_range(0, 31)), 10'($urandom_range(0, 767)), 32'($urandom)};
    if (e.ev_type == TYPE_SYNC && e.ev_code == CODE_REPORT) e.ev_code = CODE_Y;
    return e;
  endfunction

  task automatic run_random_frame();
    event_t frame[$];
    logic [BTN_REG_W-1:0] zone;
    logic [VALUE_W-1:0] touch_val;
    int unsigned shape, noise;
    bit with_touch, with_report;
    shape = $urandom_range(0, 99);
    with_touch = shape >= 5 && (shape < 80 || shape >= 88);
    with_report = shape < 95;
    if (shape < 5) noise = 0;
    else if (shape < 80) noise = $urandom_range(0, 2);
    else if (shape < 88) noise = $urandom_range(1, 6);
    else if (shape < 95) noise = $urandom_range(28, 38);
    else noise = $urandom_range(0, 3);
    if (with_touch) begin
      zone = zone_reg[$urandom_range(0, MAX_BUTTONS - 1)];
      case ($urandom_range(0, 19))
        0, 1, 2: touch_val = $urandom;
        3, 4, 5, 6, 7, 8, 9, 10: touch_val = TOUCH_UP;
        default: touch_val = TOUCH_DOWN;
      endcase
      if ($urandom_range(0, 99) < 92)
        frame.insert($urandom_range(0, frame.size()), {TYPE_ABS, CODE_X,
          pick_coord(zone[0 +: COORD_BITS], zone[2*COORD_BITS +: COORD_BITS])});
      if ($urandom_range(0, 99) < 92)
        frame.insert($urandom_range(0, frame.size()), {TYPE_ABS, CODE_Y,
          pick_coord(zone[COORD_BITS +: COORD_BITS], zone[3*COORD_BITS +: COORD_BITS])});
      if ($urandom_range(0, 99) < 92)
        frame.insert($urandom_range(0, frame.size()), {TYPE_KEY, CODE_TOUCH, touch_val});
    end
    repeat (noise) frame.insert($urandom_range(0, frame.size()), random_noise());
    foreach (frame[k]) send_event(frame[k], 1'b0);
    if (with_report) send_event({TYPE_SYNC, CODE_REPORT, 32'd0}, 1'b0);
  endtask

  // Output side: random stalls, plus one long hold-off that lets the block fill up.
  initial begin
    int unsigned hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && items_sent >= HOLD_AT_ITEMS) begin
        out_stall <= 1'b1;
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
      end else begin
        out_stall <= idle_enabled && $urandom_range(0, 99) < IDLE_PERCENT;
      end
    end
  end

  always @(posedge clk) begin
    out_event_t want;
    if (!rst && in_valid && in_stall) input_stall_cycles++;
    if (!rst && out_valid && !out_stall) begin
      results_checked++;
      if (awaited_events.size() == 0) begin
        report_mismatch($sformatf("unexpected item type %0d code %0d value %0d last %0b",
                                  out_type, out_code, out_value, out_last));
      end else begin
        want = awaited_events.pop_front();
        if (out_type !== want.ev_type || out_code !== want.ev_code ||
            out_value !== want.ev_value || out_last !== want.last)
          report_mismatch($sformatf({"got type %0d code %0d value %0d last %0b, ",
                                     "expected type %0d code %0d value %0d last %0b"},
                                    out_type, out_code, out_value, out_last, want.ev_type,
                                    want.ev_code, $signed(want.ev_value), want.last));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d items still expected", cycle_count,
             awaited_events.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    event_type = '0;
    event_code = '0;
    event_value = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_enabled = 1'b1;
    items_sent = 0;
    frames_closed = 0;
    key_presses = 0;
    key_releases = 0;
    results_checked = 0;
    input_stall_cycles = 0;
    mismatches = 0;
    latched = '0;
    zone_count = '0;
    foreach (zone_reg[i]) zone_reg[i] = '0;
    clear_frame();

    // Corner presses on button 0, the widest possible button 1, release paths,
    // extreme values and a touch value that is neither press nor release.
    directed[0]  = {TYPE_SYNC, CODE_REPORT, 32'd0,        2'd1, REPORT_LAST, NO_RESULT};
    directed[1]  = {TYPE_ABS,  CODE_X,      32'd100,      2'd0, NO_RESULT, NO_RESULT};
    directed[2]  = {TYPE_ABS,  CODE_Y,      32'd200,      2'd0, NO_RESULT, NO_RESULT};
    directed[3]  = {TYPE_KEY,  CODE_TOUCH,  TOUCH_DOWN,   2'd0, NO_RESULT, NO_RESULT};
    directed[4]  = {TYPE_SYNC, CODE_REPORT, 32'd0,        2'd2,
                    {TYPE_KEY, KEY_ZONE0, TOUCH_DOWN, 1'b0}, REPORT_LAST};
    directed[5]  = {TYPE_KEY,  CODE_TOUCH,  TOUCH_UP,     2'd0, NO_RESULT, NO_RESULT};
    directed[6]  = {TYPE_SYNC, CODE_REPORT, 32'd0,        2'd2,
                    {TYPE_KEY, KEY_ZONE0, TOUCH_UP, 1'b0}, REPORT_LAST};
    directed[7]  = {TYPE_ABS,  CODE_X,      32'd150,      2'd0, NO_RESULT, NO_RESULT};
    directed[8]  = {TYPE_ABS,  CODE_Y,      32'd240,      2'd0, NO_RESULT, NO_RESULT};
    directed[9]  = {TYPE_KEY,  CODE_TOUCH,  TOUCH_DOWN,   2'd0, NO_RESULT, NO_RESULT};
    directed[10] = {TYPE_SYNC, CODE_REPORT, 32'd0,        2'd0, NO_RESULT, NO_RESULT};
    directed[11] = {TYPE_ABS,  CODE_X,      32'd8190,     2'd0, NO_RESULT, NO_RESULT};
    directed[12] = {TYPE_ABS,  CODE_Y,      32'd8190,     2'd0, NO_RESULT, NO_RESULT};
    directed[13] = {TYPE_KEY,  CODE_TOUCH,  TOUCH_UP,     2'd0, NO_RESULT, NO_RESULT};
    directed[14] = {TYPE_SYNC, CODE_REPORT, 32'd0,        2'd0, NO_RESULT, NO_RESULT};
    directed[15] = {TYPE_KEY,  CODE_TOUCH,  TOUCH_DOWN,   2'd0, NO_RESULT, NO_RESULT};
    directed[16] = {TYPE_ABS,  CODE_X,      32'd8190,     2'd0, NO_RESULT, NO_RESULT};
    directed[17] = {TYPE_ABS,  CODE_Y,      32'd8190,     2'd0, NO_RESULT, NO_RESULT};
    directed[18] = {TYPE_SYNC, CODE_REPORT, 32'd0,        2'd0, NO_RESULT, NO_RESULT};
    directed[19] = {TYPE_ABS,  CODE_X,      32'h80000000, 2'd0, NO_RESULT, NO_RESULT};
    directed[20] = {TYPE_KEY,  CODE_TOUCH,  TOUCH_UP,     2'd0, NO_RESULT, NO_RESULT};
    directed[21] = {TYPE_SYNC, CODE_REPORT, 32'd0,        2'd0, NO_RESULT, NO_RESULT};
    directed[22] = {5'd31,     10'd767,     32'h7FFFFFFF, 2'd0, NO_RESULT, NO_RESULT};
    directed[23] = {TYPE_KEY,  CODE_TOUCH,  32'd2,        2'd0, NO_RESULT, NO_RESULT};
    directed[24] = {TYPE_SYNC, CODE_REPORT, 32'd0,        2'd0, NO_RESULT, NO_RESULT};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_register(REG_BUTTON_COUNT, BTN_REG_W'(MAX_BUTTONS));
    write_register(REG_BUTTON_ZERO, pack_button(100, 200, 50, 40, KEY_ZONE0));
    write_register(REG_BUTTON_ZERO + 3'd1, '1);
    write_register(REG_BUTTON_ZERO + 3'd2, '0);
    write_register(REG_BUTTON_THREE, pack_button(1000, 1000, 10, 10, KEY_ZONE3));
    write_register(REG_FIRST_UNUSED + 3'($urandom_range(0, 2)), '1);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_event(directed[i].ev, directed[i].n_typed != 0);
      if (directed[i].n_typed != 0) awaited_events.push_back(directed[i].typed_a);
      if (directed[i].n_typed == 2) awaited_events.push_back(directed[i].typed_b);
    end
    drain();

    // Phases: no buttons (all replays), random counts, an idle-free stretch,
    // and a count above the maximum. Latches carry over between phases.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) write_register(REG_BUTTON_COUNT, '0);
      else if (p == PHASES - 1) write_register(REG_BUTTON_COUNT, {{(BTN_REG_W-3){1'b1}}, 3'd7});
      else write_register(REG_BUTTON_COUNT, {55'({$urandom, $urandom}), 3'($urandom_range(0, 7))});
      for (int b = 0; b < MAX_BUTTONS; b++)
        write_register(REG_BUTTON_ZERO + 3'(b), random_button());
      if (p == 3) write_register(REG_FIRST_UNUSED + 3'($urandom_range(0, 2)), random_button());
      idle_enabled = p != 2;
      while (items_sent < DIRECTED_ROWS + PHASE_ITEMS * (p + 1)) run_random_frame();
      send_event({TYPE_SYNC, CODE_REPORT, 32'd0}, 1'b0);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d input items closing %0d frames; %0d key presses, %0d key releases.",
             items_sent, frames_closed, key_presses, key_releases);
    $display("Checked %0d output items; input held back for %0d cycles; %0d mismatches.",
             results_checked, input_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
src/tzkm_pkg.sv
src/tzkm_store.sv
src/tzkm_zone.sv
src/touch_zone_key_mapper_top.sv
bench/testbench.sv
